// ===== rtl/core/dtcm_pkg.sv =====
package dtcm_pkg;

    // Field widths
    localparam int RAW_W   = 12;
    localparam int THR_W   = 15;
    localparam int ANG_W   = 16;

    // Ratio divider: Q16 quotient, fixed number of quotient bits per stage
    localparam int RATIO_W      = 16;
    localparam int RATIO_STEPS  = 4;
    localparam int DIV_STAGES   = RATIO_W / RATIO_STEPS;

    // Throttle divider: quotient 0..127, saturated to 0..100
    localparam int THR_Q_W   = 7;
    localparam int THR_A_W   = 19;
    localparam int THR_STEPS = 4;

    // Whole pipeline: front end, divider stages, three back-end stages
    localparam int NUM_STAGES = DIV_STAGES + 4;

    localparam logic [THR_Q_W-1:0]  THR_FULL  = 7'd100;
    localparam logic [6:0]          THR_SCALE = 7'd100;
    localparam logic [RATIO_W:0]    Q16_ONE   = 17'h10000;
    localparam logic [14:0]         ANGLE_MID = 15'd23040;
    localparam logic [18:0]         CUT_DEN   = 19'd327680;
    // floor(y / 5) == (y * RECIP5) >> RECIP5_SH for y < 2**18
    localparam logic [15:0]         RECIP5    = 16'd52429;
    localparam int                  RECIP5_SH = 18;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_THROTTLE_MIN   = 3'd0,
        REG_THROTTLE_MAX   = 3'd1,
        REG_TURN_CENTER    = 3'd2,
        REG_TURN_MAX       = 3'd3,
        REG_SERVO_A_CENTER = 3'd4,
        REG_SERVO_A_MAX    = 3'd5,
        REG_SERVO_B_CENTER = 3'd6,
        REG_SERVO_B_MAX    = 3'd7
    } dtcm_reg_t;

    typedef struct packed {
        logic [RAW_W-1:0] throttle_min;
        logic [RAW_W-1:0] throttle_max;
        logic [RAW_W-1:0] turn_center;
        logic [RAW_W-1:0] turn_max;
        logic [RAW_W-1:0] servo_a_center;
        logic [RAW_W-1:0] servo_a_max;
        logic [RAW_W-1:0] servo_b_center;
        logic [RAW_W-1:0] servo_b_max;
    } dtcm_cfg_t;

    typedef struct packed {
        logic [RAW_W-1:0] throttle_raw;
        logic [RAW_W-1:0] turn_raw;
        logic [RAW_W-1:0] servo_a_raw;
        logic [RAW_W-1:0] servo_b_raw;
    } dtcm_stick_t;

    typedef struct packed {
        logic [THR_W-1:0] left_throttle;
        logic [THR_W-1:0] right_throttle;
        logic [ANG_W-1:0] servo_a_angle;
        logic [ANG_W-1:0] servo_b_angle;
    } dtcm_chan_t;

    // One stick deflection in flight through the ratio divider
    typedef struct packed {
        logic               up;     // above center
        logic               dn;     // below center
        logic               full;   // ratio clamped to one
        logic [RAW_W-1:0]   rem;
        logic [RAW_W-1:0]   den;
        logic [RATIO_W-1:0] q;
    } dtcm_lane_t;

    // Throttle level in flight through its divider
    typedef struct packed {
        logic               sat;    // level forced to 100
        logic [THR_A_W-1:0] rem;
        logic [RAW_W-1:0]   den;
        logic [THR_Q_W-1:0] q;
    } dtcm_thr_t;

    typedef struct packed {
        dtcm_thr_t  thr;
        dtcm_lane_t turn;
        dtcm_lane_t sa;
        dtcm_lane_t sb;
    } dtcm_work_t;

    // Back end, after the first multiply
    typedef struct packed {
        logic [THR_Q_W-1:0] level;
        logic [16:0]        cut_hi;   // T*(327680-2r) >> 8
        logic               turn_up;
        logic               turn_dn;
        logic [14:0]        sa_d;
        logic               sa_up;
        logic               sa_dn;
        logic [14:0]        sb_d;
        logic               sb_up;
        logic               sb_dn;
    } dtcm_scale_t;

    // Back end, after the reciprocal multiply
    typedef struct packed {
        logic [THR_W-1:0] base;
        logic [THR_W-1:0] cut;
        logic             turn_up;
        logic             turn_dn;
        logic [ANG_W-1:0] sa_angle;
        logic [ANG_W-1:0] sb_angle;
    } dtcm_blend_t;

endpackage

// ===== rtl/core/dtcm_prep.sv =====
// Front end: sets up each divider (operands and special cases) from sticks and calibration.
module dtcm_prep
(
    input  logic                  clk,
    input  logic                  load,
    input  dtcm_pkg::dtcm_stick_t stick,
    input  dtcm_pkg::dtcm_cfg_t   cfg,
    output dtcm_pkg::dtcm_work_t  work
);

    dtcm_pkg::dtcm_work_t work_reg;
    dtcm_pkg::dtcm_work_t work_next;

    // Deflection setup: ratio = rem/den in Q16, or a forced one / zero
    function automatic dtcm_pkg::dtcm_lane_t lane_init(
        input logic [dtcm_pkg::RAW_W-1:0] raw,
        input logic [dtcm_pkg::RAW_W-1:0] center,
        input logic [dtcm_pkg::RAW_W-1:0] maxv
    );
        dtcm_pkg::dtcm_lane_t       l;
        logic [dtcm_pkg::RAW_W-1:0] n;
        logic [dtcm_pkg::RAW_W-1:0] d;
        l     = '0;
        l.den = dtcm_pkg::RAW_W'(1);
        n     = '0;
        d     = '0;
        if (raw > center)
        begin
            l.up = 1'b1;
            n    = raw - center;
            d    = maxv - center;
            if (maxv == center)
            begin
                l.full = 1'b1;
            end
            else if (maxv > center)
            begin
                if (n >= d)
                begin
                    l.full = 1'b1;
                end
                else
                begin
                    l.rem = n;
                    l.den = d;
                end
            end
        end
        else if (raw < center)
        begin
            l.dn = 1'b1;
            n    = center - raw;
            d    = center;
            if (n >= d)
            begin
                l.full = 1'b1;
            end
            else
            begin
                l.rem = n;
                l.den = d;
            end
        end
        return l;
    endfunction

    // Throttle setup: |raw-min|*100 over |max-min| when the signs agree
    function automatic dtcm_pkg::dtcm_thr_t thr_init(
        input logic [dtcm_pkg::RAW_W-1:0] raw,
        input logic [dtcm_pkg::RAW_W-1:0] tmin,
        input logic [dtcm_pkg::RAW_W-1:0] tmax
    );
        dtcm_pkg::dtcm_thr_t          t;
        logic signed [dtcm_pkg::RAW_W:0] num;
        logic signed [dtcm_pkg::RAW_W:0] den;
        logic [dtcm_pkg::RAW_W:0]     num_mag;
        logic [dtcm_pkg::RAW_W:0]     den_mag;
        logic [dtcm_pkg::THR_A_W-1:0] a;
        logic [dtcm_pkg::THR_A_W-1:0] b_top;
        t       = '0;
        t.den   = dtcm_pkg::RAW_W'(1);
        num     = $signed({1'b0, raw}) - $signed({1'b0, tmin});
        den     = $signed({1'b0, tmax}) - $signed({1'b0, tmin});
        num_mag = num[dtcm_pkg::RAW_W] ? 13'(-num) : 13'(num);
        den_mag = den[dtcm_pkg::RAW_W] ? 13'(-den) : 13'(den);
        a       = dtcm_pkg::THR_A_W'(num_mag[dtcm_pkg::RAW_W-1:0])
                  * dtcm_pkg::THR_A_W'(dtcm_pkg::THR_SCALE);
        b_top   = dtcm_pkg::THR_A_W'(den_mag[dtcm_pkg::RAW_W-1:0]) << dtcm_pkg::THR_Q_W;
        if (den == '0)
        begin
            t.sat = (raw >= tmin);
        end
        else if ((num != '0) && (num[dtcm_pkg::RAW_W] == den[dtcm_pkg::RAW_W]))
        begin
            if (a >= b_top)
            begin
                t.sat = 1'b1;
            end
            else
            begin
                t.rem = a;
                t.den = den_mag[dtcm_pkg::RAW_W-1:0];
            end
        end
        return t;
    endfunction

    always_comb
    begin
        work_next.thr  = thr_init(stick.throttle_raw, cfg.throttle_min, cfg.throttle_max);
        work_next.turn = lane_init(stick.turn_raw, cfg.turn_center, cfg.turn_max);
        work_next.sa   = lane_init(stick.servo_a_raw, cfg.servo_a_center, cfg.servo_a_max);
        work_next.sb   = lane_init(stick.servo_b_raw, cfg.servo_b_center, cfg.servo_b_max);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            work_reg <= work_next;
        end
    end

    assign work = work_reg;

endmodule

// ===== rtl/core/dtcm_div_stage.sv =====
// One divider stage: a few restoring steps on each ratio lane and on the throttle.
module dtcm_div_stage
#(
    parameter int THR_STEPS = 0,   // throttle quotient bits in this stage
    parameter int THR_SHIFT = 0    // divisor shift of the first of them
)
(
    input  logic                 clk,
    input  logic                 load,
    input  dtcm_pkg::dtcm_work_t work_in,
    output dtcm_pkg::dtcm_work_t work_out
);

    dtcm_pkg::dtcm_work_t work_reg;
    dtcm_pkg::dtcm_work_t work_next;

    // Fractional bits: double the remainder, subtract the divisor if it fits
    function automatic dtcm_pkg::dtcm_lane_t ratio_steps(input dtcm_pkg::dtcm_lane_t l);
        dtcm_pkg::dtcm_lane_t     o;
        logic [dtcm_pkg::RAW_W:0] r2;
        o = l;
        for (int k = 0; k < dtcm_pkg::RATIO_STEPS; k++)
        begin
            r2 = {o.rem, 1'b0};
            if (r2 >= {1'b0, o.den})
            begin
                o.rem = dtcm_pkg::RAW_W'(r2 - {1'b0, o.den});
                o.q   = {o.q[dtcm_pkg::RATIO_W-2:0], 1'b1};
            end
            else
            begin
                o.rem = r2[dtcm_pkg::RAW_W-1:0];
                o.q   = {o.q[dtcm_pkg::RATIO_W-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    // Integer bits: compare against the divisor shifted to the current bit
    function automatic dtcm_pkg::dtcm_thr_t thr_steps(input dtcm_pkg::dtcm_thr_t t);
        dtcm_pkg::dtcm_thr_t          o;
        logic [dtcm_pkg::THR_A_W-1:0] dsh;
        o = t;
        for (int k = 0; k < THR_STEPS; k++)
        begin
            dsh = dtcm_pkg::THR_A_W'(o.den) << (THR_SHIFT - k);
            if (o.rem >= dsh)
            begin
                o.rem = o.rem - dsh;
                o.q   = {o.q[dtcm_pkg::THR_Q_W-2:0], 1'b1};
            end
            else
            begin
                o.q   = {o.q[dtcm_pkg::THR_Q_W-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    always_comb
    begin
        work_next.thr  = thr_steps(work_in.thr);
        work_next.turn = ratio_steps(work_in.turn);
        work_next.sa   = ratio_steps(work_in.sa);
        work_next.sb   = ratio_steps(work_in.sb);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            work_reg <= work_next;
        end
    end

    assign work_out = work_reg;

endmodule

// ===== rtl/core/dtcm_mix.sv =====
// Back end: scale ratios, apply the turn cut, form servo angles and the final channels.
module dtcm_mix
(
    input  logic                 clk,
    input  logic [2:0]           load,     // one enable per back-end stage
    input  dtcm_pkg::dtcm_work_t work,
    output dtcm_pkg::dtcm_chan_t chan
);

    dtcm_pkg::dtcm_scale_t scale_reg;
    dtcm_pkg::dtcm_scale_t scale_next;
    dtcm_pkg::dtcm_blend_t blend_reg;
    dtcm_pkg::dtcm_blend_t blend_next;
    dtcm_pkg::dtcm_chan_t  chan_reg;
    dtcm_pkg::dtcm_chan_t  chan_next;

    logic [dtcm_pkg::RATIO_W:0] r_turn;
    logic [dtcm_pkg::RATIO_W:0] r_sa;
    logic [dtcm_pkg::RATIO_W:0] r_sb;
    logic [31:0]                sa_prod;
    logic [31:0]                sb_prod;
    logic [18:0]                cut_mul;
    logic [25:0]                cut_prod;
    logic [33:0]                recip_prod;

    // Stage A: clamp ratios, saturate throttle, first multiplies
    always_comb
    begin
        r_turn = work.turn.full ? dtcm_pkg::Q16_ONE : {1'b0, work.turn.q};
        r_sa   = work.sa.full   ? dtcm_pkg::Q16_ONE : {1'b0, work.sa.q};
        r_sb   = work.sb.full   ? dtcm_pkg::Q16_ONE : {1'b0, work.sb.q};

        if (work.thr.sat || (work.thr.q > dtcm_pkg::THR_FULL))
        begin
            scale_next.level = dtcm_pkg::THR_FULL;
        end
        else
        begin
            scale_next.level = work.thr.q;
        end

        sa_prod  = 32'(r_sa) * 32'(dtcm_pkg::ANGLE_MID);
        sb_prod  = 32'(r_sb) * 32'(dtcm_pkg::ANGLE_MID);
        cut_mul  = dtcm_pkg::CUT_DEN - 19'({r_turn, 1'b0});
        cut_prod = 26'(scale_next.level) * 26'(cut_mul);

        scale_next.cut_hi  = cut_prod[24:8];
        scale_next.turn_up = work.turn.up;
        scale_next.turn_dn = work.turn.dn;
        scale_next.sa_d    = sa_prod[30:16];
        scale_next.sa_up   = work.sa.up;
        scale_next.sa_dn   = work.sa.dn;
        scale_next.sb_d    = sb_prod[30:16];
        scale_next.sb_up   = work.sb.up;
        scale_next.sb_dn   = work.sb.dn;
    end

    // Stage B: divide by five through the reciprocal, servo offsets
    always_comb
    begin
        recip_prod         = 34'(scale_reg.cut_hi) * 34'(dtcm_pkg::RECIP5);
        blend_next.cut     = recip_prod[dtcm_pkg::RECIP5_SH +: dtcm_pkg::THR_W];
        blend_next.base    = {scale_reg.level, 8'd0};
        blend_next.turn_up = scale_reg.turn_up;
        blend_next.turn_dn = scale_reg.turn_dn;

        if (scale_reg.sa_up)
        begin
            blend_next.sa_angle = 16'(dtcm_pkg::ANGLE_MID) + 16'(scale_reg.sa_d);
        end
        else if (scale_reg.sa_dn)
        begin
            blend_next.sa_angle = 16'(dtcm_pkg::ANGLE_MID) - 16'(scale_reg.sa_d);
        end
        else
        begin
            blend_next.sa_angle = 16'(dtcm_pkg::ANGLE_MID);
        end

        if (scale_reg.sb_up)
        begin
            blend_next.sb_angle = 16'(dtcm_pkg::ANGLE_MID) + 16'(scale_reg.sb_d);
        end
        else if (scale_reg.sb_dn)
        begin
            blend_next.sb_angle = 16'(dtcm_pkg::ANGLE_MID) - 16'(scale_reg.sb_d);
        end
        else
        begin
            blend_next.sb_angle = 16'(dtcm_pkg::ANGLE_MID);
        end
    end

    // Stage C: turn above center cuts the right side, below center the left
    always_comb
    begin
        chan_next.left_throttle  = blend_reg.turn_dn ? blend_reg.cut : blend_reg.base;
        chan_next.right_throttle = blend_reg.turn_up ? blend_reg.cut : blend_reg.base;
        chan_next.servo_a_angle  = blend_reg.sa_angle;
        chan_next.servo_b_angle  = blend_reg.sb_angle;
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            scale_reg <= scale_next;
        end
        if (load[1])
        begin
            blend_reg <= blend_next;
        end
        if (load[2])
        begin
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

// ===== rtl/core/differential_throttle_channel_mixer.sv =====
// Differential-thrust channel mixer. Each transfer on the stick channel carries four raw
// 12-bit samples; each transfer on the chan channel returns left/right throttle (0..100,
// 8 fractional bits) and two servo angles (0..180 degrees, 8 fractional bits), in order.
// The block is an 8-stage pipeline: a setup stage, four divider stages that each resolve
// four bits of the Q16 stick ratios (the first two also split the throttle quotient), and three
// back-end stages (scale multiply, divide-by-five reciprocal multiply, channel select).
// It accepts one sample set every cycle unless back-pressure on chan stalls the setup
// stage; chan_valid is the valid bit of the select stage, the last of the eight.
// Back-pressure on chan stalls only stages that hold data, so bubbles close
// up. Calibration registers are written through cfg at any time (cfg_ready is always
// high) but must only change while no sample set is in flight.
module differential_throttle_channel_mixer
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  stick_valid,
    output logic                  stick_ready,
    input  dtcm_pkg::dtcm_stick_t stick,

    output logic                  chan_valid,
    input  logic                  chan_ready,
    output dtcm_pkg::dtcm_chan_t  chan,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [11:0]           cfg_data
);

    localparam int NS = dtcm_pkg::NUM_STAGES;
    localparam int DS = dtcm_pkg::DIV_STAGES;

    dtcm_pkg::dtcm_cfg_t  cfg_reg;
    dtcm_pkg::dtcm_cfg_t  cfg_next;
    logic [NS-1:0]        valid_reg;
    logic [NS-1:0]        valid_next;
    logic [NS-1:0]        adv;
    dtcm_pkg::dtcm_work_t work [DS+1];

    // Calibration register writes
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (dtcm_pkg::dtcm_reg_t'(cfg_index))
                dtcm_pkg::REG_THROTTLE_MIN:   cfg_next.throttle_min   = cfg_data;
                dtcm_pkg::REG_THROTTLE_MAX:   cfg_next.throttle_max   = cfg_data;
                dtcm_pkg::REG_TURN_CENTER:    cfg_next.turn_center    = cfg_data;
                dtcm_pkg::REG_TURN_MAX:       cfg_next.turn_max       = cfg_data;
                dtcm_pkg::REG_SERVO_A_CENTER: cfg_next.servo_a_center = cfg_data;
                dtcm_pkg::REG_SERVO_A_MAX:    cfg_next.servo_a_max    = cfg_data;
                dtcm_pkg::REG_SERVO_B_CENTER: cfg_next.servo_b_center = cfg_data;
                dtcm_pkg::REG_SERVO_B_MAX:    cfg_next.servo_b_max    = cfg_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.throttle_min   <= 12'd0;
            cfg_reg.throttle_max   <= 12'd4095;
            cfg_reg.turn_center    <= 12'd2048;
            cfg_reg.turn_max       <= 12'd4095;
            cfg_reg.servo_a_center <= 12'd2048;
            cfg_reg.servo_a_max    <= 12'd4095;
            cfg_reg.servo_b_center <= 12'd2048;
            cfg_reg.servo_b_max    <= 12'd4095;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Stage advance: a stage loads when it is empty or its content moves on
    always_comb
    begin
        adv[NS-1] = !valid_reg[NS-1] || chan_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < NS; i++)
        begin
            if (adv[i])
            begin
                valid_next[i] = (i == 0) ? stick_valid : valid_reg[(i == 0) ? 0 : i - 1];
            end
            else
            begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign stick_ready = adv[0];
    assign chan_valid  = valid_reg[NS-1];

    // Setup stage
    dtcm_prep u_prep
    (
        .clk   (clk),
        .load  (adv[0]),
        .stick (stick),
        .cfg   (cfg_reg),
        .work  (work[0])
    );

    // Divider stages
    for (genvar g = 0; g < DS; g++)
    begin : g_div
        localparam int LEFT  = dtcm_pkg::THR_Q_W - dtcm_pkg::THR_STEPS * g;
        localparam int STEPS = (LEFT <= 0) ? 0 :
                               ((LEFT > dtcm_pkg::THR_STEPS) ? dtcm_pkg::THR_STEPS : LEFT);
        localparam int SHIFT = (LEFT <= 0) ? 0 : LEFT - 1;

        dtcm_div_stage
        #(
            .THR_STEPS (STEPS),
            .THR_SHIFT (SHIFT)
        )
        u_div
        (
            .clk      (clk),
            .load     (adv[g+1]),
            .work_in  (work[g]),
            .work_out (work[g+1])
        );
    end

    // Scale, reciprocal and select stages
    dtcm_mix u_mix
    (
        .clk  (clk),
        .load (adv[NS-1:NS-3]),
        .work (work[DS]),
        .chan (chan)
    );

endmodule
